// ===== hdl/lkv_pkg.sv =====
// Shared types and constants for the linear key-value table.
package lkv_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned STATUS_W      = 2;

  localparam int unsigned DEF_ENTRIES    = 16;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_GET    = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_EXEC = 1'b1
  } bstate_t;

  // Request as it leaves the front: raw key/data plus decoded mode flags.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic              is_read;
    logic              use_default;
    logic              is_write;
    logic              is_delete;
  } req_t;

endpackage

// ===== hdl/lkv_front.sv =====
// Front end: accepts requests, decodes the mode and buffers them in a short queue.
module lkv_front #(
  parameter int unsigned QDEPTH = lkv_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lkv_pkg::MODE_W-1:0] in_mode,
  input  logic [lkv_pkg::KEY_W-1:0]  in_key,
  input  logic [lkv_pkg::DATA_W-1:0] in_data_in,
  output lkv_pkg::req_t              head,
  output logic                       head_valid,
  input  logic                       pop
);
  import lkv_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  req_t           q_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push;
  req_t           cls;
  mode_t          mode;

  // decode
  always_comb begin
    mode            = mode_t'(in_mode);
    cls.key         = in_key;
    cls.data        = in_data_in;
    cls.is_read     = mode inside {MODE_LOOKUP, MODE_GET};
    cls.use_default = (mode == MODE_GET);
    cls.is_write    = (mode == MODE_WRITE);
    cls.is_delete   = (mode == MODE_DELETE);
  end

  assign in_ready   = (cnt_r != CW'(QDEPTH));
  assign push       = in_valid & in_ready;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hdl/lkv_back.sv =====
// Back end: holds the table, searches it, applies the request and registers the result.
module lkv_back #(
  parameter int unsigned ENTRIES    = lkv_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lkv_pkg::req_t                head,
  input  logic                         head_valid,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [lkv_pkg::DATA_W-1:0]   out_data_out,
  output logic [lkv_pkg::STATUS_W-1:0] out_status,
  output logic [lkv_pkg::COUNT_W-1:0]  out_entry_count
);
  import lkv_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0]   key_r [ENTRIES];
  logic [VALUE_BITS-1:0] val_r [ENTRIES];
  logic [CW-1:0]         count_r, count_nxt;
  bstate_t               state_r, state_nxt;
  req_t                  req_r;
  logic [ENTRIES-1:0]    hit_r, hit_nxt;
  logic [ENTRIES-1:0]    shift_r, shift_nxt;

  logic                  commit;
  logic                  hit;
  logic                  full;
  logic [VALUE_BITS-1:0] hit_val;
  logic [KEY_BITS-1:0]   head_key, req_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic                  found;
  logic [DATA_W-1:0]     data;
  status_t               status;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [DATA_W-1:0]     out_data_r;
  status_t               out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  // parallel compare against the queue head, only over occupied slots
  always_comb begin
    head_key = KEY_BITS'(head.key);
    for (int i = 0; i < ENTRIES; i++) begin
      hit_nxt[i] = (CW'(i) < count_r) && (key_r[i] == head_key);
    end
    // slots at or above the hit take their upper neighbor on delete
    shift_nxt[0] = hit_nxt[0];
    for (int i = 1; i < ENTRIES; i++) begin
      shift_nxt[i] = hit_nxt[i] | shift_nxt[i-1];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (head_valid) state_nxt = B_EXEC;
      B_EXEC:  if (commit) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    case (state_r)
      B_IDLE:  pop = head_valid;
      B_EXEC:  commit = !out_valid_r || out_ready;
      default: begin
        pop    = 1'b0;
        commit = 1'b0;
      end
    endcase
  end

  // request evaluation on the registered match vector
  always_comb begin
    req_key = KEY_BITS'(req_r.key);
    wr_val  = VALUE_BITS'(req_r.data);
    hit     = |hit_r;
    full    = (count_r == CW'(ENTRIES));
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val = hit_val | (hit_r[i] ? val_r[i] : '0);
    end

    found     = hit;
    data      = '0;
    status    = ST_OK;
    count_nxt = count_r;
    if (req_r.is_read) begin
      if (hit) begin
        data = DATA_W'(hit_val);
      end else begin
        status = ST_MISS;
        if (req_r.use_default) data = req_r.data;
      end
    end else if (req_r.is_write) begin
      if (!hit) begin
        if (full) status = ST_FULL;
        else      count_nxt = count_r + 1'b1;
      end
    end else begin
      if (hit) count_nxt = count_r - 1'b1;
      else     status = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req_r   <= head;
      hit_r   <= hit_nxt;
      shift_r <= shift_nxt;
    end
    if (commit) begin
      out_found_r  <= found;
      out_data_r   <= data;
      out_status_r <= status;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  // table write-back
  always_ff @(posedge clk) begin
    if (commit) begin
      if (req_r.is_write) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit) begin
            if (hit_r[i]) val_r[i] <= wr_val;
          end else if (!full && count_r == CW'(i)) begin
            key_r[i] <= req_key;
            val_r[i] <= wr_val;
          end
        end
      end else if (req_r.is_delete && hit) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          if (shift_r[i]) begin
            key_r[i] <= key_r[i+1];
            val_r[i] <= val_r[i+1];
          end
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_data_out    = out_data_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== hdl/linear_key_value_table.sv =====
// Top level of the linear key-value table: request queue front, table back end.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid / in_ready    | in_mode, in_key, in_data_in
//   out     | out_valid / out_ready  | out_found, out_data_out, out_status,
//           |                        | out_entry_count
//
// Requests are taken one at a time: a compare step over all slots, then a commit step
// that writes back, appends or shifts the table and loads the result register.
// A request passes the queue and the request register before the result register.
// Reset clears the queue, the fill count and the result valid; slot contents are
// left as they are, no clearing pass. A stalled result holds the commit; the
// front queue keeps accepting until it is full.
module linear_key_value_table #(
  parameter int unsigned ENTRIES     = lkv_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS    = lkv_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS  = lkv_pkg::DEF_VALUE_BITS,
  parameter int unsigned QUEUE_DEPTH = lkv_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lkv_pkg::MODE_W-1:0]   in_mode,
  input  logic [lkv_pkg::KEY_W-1:0]    in_key,
  input  logic [lkv_pkg::DATA_W-1:0]   in_data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [lkv_pkg::DATA_W-1:0]   out_data_out,
  output logic [lkv_pkg::STATUS_W-1:0] out_status,
  output logic [lkv_pkg::COUNT_W-1:0]  out_entry_count
);
  import lkv_pkg::*;

  req_t head;
  logic head_valid;
  logic pop;

  lkv_front #(
    .QDEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_key    (in_key),
    .in_data_in(in_data_in),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  lkv_back #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

`ifndef SYNTHESIS
  // the back end never takes from an empty queue
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty request queue");

  // a full report only comes with a table at capacity and no hit
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (!out_found && out_entry_count == COUNT_W'(ENTRIES)))
    else $error("full status with inconsistent found or count");

  // a miss never reports the key as present
  a_miss_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MISS) |-> !out_found)
    else $error("miss status with found set");

  // a new result transfer cannot follow another one on the next cycle
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |=> !$rose(out_valid))
    else $error("results closer than the two-cycle request spacing");
`endif

endmodule

// ===== test/tb_linear_key_value_table.sv =====
`timescale 1ns / 100ps
// Testbench for linear_key_value_table: directed and randomized requests checked against a table predictor.
module tb_linear_key_value_table;
  import lkv_pkg::*;

  localparam int unsigned SLOTS = DEF_ENTRIES;
  localparam int unsigned POOL_SIZE = 24;

  typedef struct packed {
    logic                found;
    logic [DATA_W-1:0]   data;
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode = MODE_LOOKUP;
  logic [KEY_W-1:0]    in_key = '0;
  logic [DATA_W-1:0]   in_data_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_found;
  logic [DATA_W-1:0]   out_data_out;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_entry_count;

  // predictor state: packed list of pairs, same order as the block keeps them
  logic [KEY_W-1:0]  tbl_keys [SLOTS];
  logic [DATA_W-1:0] tbl_vals [SLOTS];
  int unsigned       tbl_count = 0;

  lookup_result_t    pending_results [$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit fill_bias = 1'b1;

  int fail_count = 0;
  int sent_count = 0;
  int result_count = 0;
  int hit_count = 0;
  int full_count = 0;
  int delete_count = 0;

  linear_key_value_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_data_out    (out_data_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always #6 clk = ~clk;

  // Applies one request to the predicted table and returns the result it should produce.
  function automatic lookup_result_t table_apply(input mode_t mode, input logic [KEY_W-1:0] key,
                                                 input logic [DATA_W-1:0] din);
    lookup_result_t r;
    int slot;
    int i;
    slot = -1;
    for (i = 0; i < tbl_count; i++)
      if (slot < 0 && tbl_keys[i] == key) slot = i;
    r.found  = (slot >= 0);
    r.data   = '0;
    r.status = ST_OK;
    case (mode)
      MODE_LOOKUP: begin
        if (slot >= 0) r.data = tbl_vals[slot];
        else r.status = ST_MISS;
      end
      MODE_GET: begin
        if (slot >= 0) r.data = tbl_vals[slot];
        else begin
          r.data   = din;
          r.status = ST_MISS;
        end
      end
      MODE_WRITE: begin
        if (slot >= 0) tbl_vals[slot] = din;
        else if (tbl_count < SLOTS) begin
          tbl_keys[tbl_count] = key;
          tbl_vals[tbl_count] = din;
          tbl_count++;
        end else r.status = ST_FULL;
      end
      default: begin
        if (slot >= 0) begin
          for (i = slot + 1; i < tbl_count; i++) begin
            tbl_keys[i-1] = tbl_keys[i];
            tbl_vals[i-1] = tbl_vals[i];
          end
          tbl_count--;
        end else r.status = ST_MISS;
      end
    endcase
    r.count = COUNT_W'(tbl_count);
    if (r.found) hit_count++;
    if (r.status == ST_FULL) full_count++;
    if (mode == MODE_DELETE && r.found) delete_count++;
    return r;
  endfunction

  task automatic send_request(input mode_t mode, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_key     <= key;
    in_data_in <= data;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(table_apply(mode, key, data));
    sent_count++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic refill_key_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
  endtask

  // Mostly keys that are held or about to be, so hits, appends, deletes and full
  // writes all happen often; a few fully random keys and extreme values mixed in.
  task automatic send_random_request();
    mode_t mode;
    logic [KEY_W-1:0] key;
    logic [DATA_W-1:0] data;
    int r;
    r = $urandom_range(99);
    if (fill_bias) begin
      if (r < 50) mode = MODE_WRITE;
      else if (r < 62) mode = MODE_DELETE;
      else if (r < 82) mode = MODE_LOOKUP;
      else mode = MODE_GET;
    end else begin
      if (r < 25) mode = MODE_WRITE;
      else if (r < 55) mode = MODE_DELETE;
      else if (r < 78) mode = MODE_LOOKUP;
      else mode = MODE_GET;
    end
    r = $urandom_range(99);
    if (r < 8) key = $urandom;
    else if (r < 50 && tbl_count > 0) key = tbl_keys[$urandom_range(tbl_count - 1)];
    else key = key_pool[$urandom_range(POOL_SIZE - 1)];
    r = $urandom_range(99);
    if (r < 5) data = '0;
    else if (r < 10) data = '1;
    else data = $urandom;
    send_request(mode, key, data);
  endtask

  task automatic test_directed_cases();
    int i;
    send_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // lookup on empty
    send_request(MODE_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);   // get miss returns default
    send_request(MODE_DELETE, 32'h0000_0000, 32'h0000_0000);   // delete on empty
    send_request(MODE_WRITE,  32'h0000_0000, 32'h0000_0000);
    send_request(MODE_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET,    32'hFFFF_FFFF, 32'h0000_0000);   // get hit ignores default
    send_request(MODE_WRITE,  32'h0000_0000, 32'hA5A5_5A5A);   // update in place
    send_request(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    for (i = 1; i <= SLOTS - 2; i++)
      send_request(MODE_WRITE, 32'h8000_0000 >> i, ~(32'h1 << i));
    send_request(MODE_WRITE,  32'hDEAD_BEEF, 32'h1234_5678);   // append refused when full
    send_request(MODE_DELETE, 32'h8000_0000 >> 7, 32'h0);      // middle slot, later pairs shift
    send_request(MODE_DELETE, 32'h0000_0000, 32'h0);           // first slot
    send_request(MODE_LOOKUP, 32'h8000_0000 >> 7, 32'h0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int i;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    refill_key_pool();
    for (i = 0; i < n_items; i++) begin
      if (i % 64 == 0) fill_bias = ~fill_bias;
      send_random_request();
    end
    wait_for_results();
  endtask

  // Receiver holds off long enough for the front queue to fill and drop in_ready.
  task automatic test_result_backpressure();
    int i;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(posedge clk);
    hold_request = 150;
    for (i = 0; i < 40; i++) send_random_request();
    wait_for_results();
  endtask

  // Sender stops until the block has delivered everything, then resumes.
  task automatic test_sender_pause();
    int i;
    snd_idle_pct = 10;
    rcv_idle_pct = 30;
    for (i = 0; i < 20; i++) send_random_request();
    wait_for_results();
    for (i = 0; i < 20; i++) send_random_request();
    wait_for_results();
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_found);
          fail_count++;
        end
        if (out_data_out !== exp_r.data) begin
          $error("data_out: expected %h, got %h", exp_r.data, out_data_out);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_entry_count !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("linear_key_value_table verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(600, 17, 57);
    test_random_traffic(600, 57, 17);
    test_random_traffic(450, 0, 0);
    test_result_backpressure();
    test_sender_pause();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Run covered %0d requests and %0d results: %0d key hits, %0d deletes,",
             sent_count, result_count, hit_count, delete_count);
    $display("%0d writes refused on a full table, under sender and receiver stalls.",
             full_count);
    if (fail_count == 0) begin
      $display("linear_key_value_table verification clean");
    end else begin
      $display("linear_key_value_table verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lkv_pkg.sv
hdl/lkv_front.sv
hdl/lkv_back.sv
hdl/linear_key_value_table.sv
test/tb_linear_key_value_table.sv
